@@ rtl/core/tsg_pkg.sv @@
// ----------------------------------------------------------------------------
// tsg_pkg
// Shared types, codes and constants of the triangle span generator.
// ----------------------------------------------------------------------------
package tsg_pkg;

    localparam int FIELD_BITS      = 12;  // width of vertex and span ports
    localparam int COORD_BITS_DEF  = 12;  // default internal coordinate width
    localparam int NUM_EDGES       = 3;

    typedef logic [1:0] edge_idx_t;

    // Edge indexes: (A,B), (A,C), (C,B)
    localparam edge_idx_t EDGE_AB = 2'd0;
    localparam edge_idx_t EDGE_AC = 2'd1;
    localparam edge_idx_t EDGE_CB = 2'd2;

    // Operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_NEXT = 1'b1;

    // Bresenham octant codes
    typedef logic [1:0] octant_t;
    localparam octant_t OCT_X_RIGHT = 2'd0;
    localparam octant_t OCT_Y_RIGHT = 2'd1;
    localparam octant_t OCT_Y_LEFT  = 2'd2;
    localparam octant_t OCT_X_LEFT  = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic load;         // set up the three walkers from the vertex ports
        logic select;       // pick long/short edges, emit the load result
        logic capture_old;  // remember long edge row
        logic adv_long;     // one step of the long edge
        logic pick;         // choose the active short edge
        logic adv_short;    // one step of the active short edge
        logic emit_span;    // emit a span result
        logic emit_empty;   // emit a no-span result
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic long_done;     // long edge at or past its last row
        logic long_moved;    // long edge row differs from captured row
        logic short_behind;  // active short edge above long edge row
    } dp_status_t;

    function automatic edge_idx_t edge_next(input edge_idx_t e);
        edge_idx_t r;
        case (e)
            EDGE_AB: r = EDGE_AC;
            EDGE_AC: r = EDGE_CB;
            default: r = EDGE_AB;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/core/tsg_datapath.sv @@
// ----------------------------------------------------------------------------
// tsg_datapath
// Walker registers, edge setup, shared Bresenham step unit, result registers.
// ----------------------------------------------------------------------------
module tsg_datapath #(
    parameter int COORD_BITS = tsg_pkg::COORD_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  tsg_pkg::dp_cmd_t                 cmd,
    output tsg_pkg::dp_status_t              status,
    input  logic [tsg_pkg::FIELD_BITS-1:0]   vertex_a_x,
    input  logic [tsg_pkg::FIELD_BITS-1:0]   vertex_a_y,
    input  logic [tsg_pkg::FIELD_BITS-1:0]   vertex_b_x,
    input  logic [tsg_pkg::FIELD_BITS-1:0]   vertex_b_y,
    input  logic [tsg_pkg::FIELD_BITS-1:0]   vertex_c_x,
    input  logic [tsg_pkg::FIELD_BITS-1:0]   vertex_c_y,
    output logic                             result_valid,
    output logic                             span_valid,
    output logic                             span_done,
    output logic [tsg_pkg::FIELD_BITS-1:0]   span_row,
    output logic [tsg_pkg::FIELD_BITS-1:0]   span_x_start,
    output logic [tsg_pkg::FIELD_BITS-1:0]   span_x_end,
    output logic                             span_zero_width
);
    import tsg_pkg::*;

    localparam int XW = COORD_BITS + 1;  // walker position
    localparam int DW = COORD_BITS + 3;  // decision / diagonal increment
    localparam int EW = COORD_BITS + 2;  // straight increment

    typedef logic [COORD_BITS-1:0] coord_t;

    logic signed [XW-1:0] walker_x_reg         [NUM_EDGES];
    logic signed [XW-1:0] walker_y_reg         [NUM_EDGES];
    coord_t               walker_y_begin_reg   [NUM_EDGES];
    coord_t               walker_y_end_reg     [NUM_EDGES];
    logic signed [DW-1:0] walker_decision_reg  [NUM_EDGES];
    logic        [EW-1:0] walker_step_even_reg [NUM_EDGES];
    logic signed [DW-1:0] walker_step_diag_reg [NUM_EDGES];
    octant_t              walker_octant_reg    [NUM_EDGES];
    edge_idx_t            long_edge_sel_reg;
    edge_idx_t            short_first_sel_reg;
    edge_idx_t            short_second_sel_reg;
    edge_idx_t            short_active_reg;
    logic signed [XW-1:0] old_y_reg;

    logic                 result_valid_reg, span_valid_reg, span_done_reg, span_zero_width_reg;
    logic [FIELD_BITS-1:0] span_row_reg, span_x_start_reg, span_x_end_reg;

    // edge setup, all edges in parallel
    coord_t               px1 [NUM_EDGES];
    coord_t               py1 [NUM_EDGES];
    coord_t               px2 [NUM_EDGES];
    coord_t               py2 [NUM_EDGES];
    logic signed [XW-1:0] su_x    [NUM_EDGES];
    coord_t               su_yb   [NUM_EDGES];
    coord_t               su_ye   [NUM_EDGES];
    logic signed [DW-1:0] su_dec  [NUM_EDGES];
    logic        [EW-1:0] su_se   [NUM_EDGES];
    logic signed [DW-1:0] su_sd   [NUM_EDGES];
    octant_t              su_oct  [NUM_EDGES];

    always_comb
    begin
        coord_t               xb, yb, xe, ye, dy, adx, dmaj, dmin;
        logic signed [XW-1:0] dx;
        octant_t              oct;
        px1[EDGE_AB] = coord_t'(vertex_a_x); py1[EDGE_AB] = coord_t'(vertex_a_y);
        px2[EDGE_AB] = coord_t'(vertex_b_x); py2[EDGE_AB] = coord_t'(vertex_b_y);
        px1[EDGE_AC] = coord_t'(vertex_a_x); py1[EDGE_AC] = coord_t'(vertex_a_y);
        px2[EDGE_AC] = coord_t'(vertex_c_x); py2[EDGE_AC] = coord_t'(vertex_c_y);
        px1[EDGE_CB] = coord_t'(vertex_c_x); py1[EDGE_CB] = coord_t'(vertex_c_y);
        px2[EDGE_CB] = coord_t'(vertex_b_x); py2[EDGE_CB] = coord_t'(vertex_b_y);
        for (int e = 0; e < NUM_EDGES; e++)
        begin
            // start at the smaller y; on equal y at the second vertex
            if (py1[e] < py2[e])
            begin
                xb = px1[e]; yb = py1[e]; xe = px2[e]; ye = py2[e];
            end
            else
            begin
                xb = px2[e]; yb = py2[e]; xe = px1[e]; ye = py1[e];
            end
            dx  = $signed({1'b0, xe}) - $signed({1'b0, xb});
            dy  = ye - yb;
            adx = dx[XW-1] ? coord_t'(-dx) : coord_t'(dx);
            if (!dx[XW-1])
                oct = (dy > adx) ? OCT_Y_RIGHT : OCT_X_RIGHT;
            else
                oct = (dy > adx) ? OCT_Y_LEFT : OCT_X_LEFT;
            if (oct == OCT_Y_RIGHT || oct == OCT_Y_LEFT)
            begin
                dmaj = dy;  dmin = adx;
            end
            else
            begin
                dmaj = adx; dmin = dy;
            end
            su_x[e]   = $signed({1'b0, xb});
            su_yb[e]  = yb;
            su_ye[e]  = ye;
            su_oct[e] = oct;
            su_se[e]  = {1'b0, dmin, 1'b0};
            su_dec[e] = $signed({2'b00, dmin, 1'b0}) - $signed({3'b000, dmaj});
            su_sd[e]  = $signed({2'b00, dmin, 1'b0}) - $signed({2'b00, dmaj, 1'b0});
        end
    end

    // ---------------- long / short edge pick ----------------
    edge_idx_t sel_long, sel_p, sel_q;
    coord_t    sel_best;

    always_comb
    begin
        coord_t len;
        sel_long = EDGE_AB;
        sel_best = '0;
        for (int e = 0; e < NUM_EDGES; e++)
        begin
            len = walker_y_end_reg[e] - walker_y_begin_reg[e];
            if (len > sel_best)
            begin
                sel_best = len;
                sel_long = edge_idx_t'(e);
            end
        end
        sel_p = edge_next(sel_long);
        sel_q = edge_next(sel_p);
    end

    // ---------------- status ----------------
    logic signed [XW-1:0] long_y, short_y;
    assign long_y  = walker_y_reg[long_edge_sel_reg];
    assign short_y = walker_y_reg[short_active_reg];

    assign status.long_done =
        long_y >= $signed({1'b0, walker_y_end_reg[long_edge_sel_reg]});
    assign status.long_moved   = long_y != old_y_reg;
    assign status.short_behind = long_y > short_y;

    logic pick_first;
    assign pick_first = long_y <= $signed({1'b0, walker_y_end_reg[short_first_sel_reg]});

    // ---------------- shared step unit ----------------
    edge_idx_t            adv_idx;
    logic signed [XW-1:0] adv_x, adv_y;
    logic signed [DW-1:0] adv_dec;
    logic                 adv_diag;

    assign adv_idx = cmd.adv_long ? long_edge_sel_reg : short_active_reg;

    always_comb
    begin
        adv_x    = walker_x_reg[adv_idx];
        adv_y    = walker_y_reg[adv_idx];
        adv_diag = !walker_decision_reg[adv_idx][DW-1];
        case (walker_octant_reg[adv_idx])
            OCT_X_RIGHT:
            begin
                adv_x = adv_x + XW'(1);
                if (adv_diag) adv_y = adv_y + XW'(1);
            end
            OCT_Y_RIGHT:
            begin
                adv_y = adv_y + XW'(1);
                if (adv_diag) adv_x = adv_x + XW'(1);
            end
            OCT_Y_LEFT:
            begin
                adv_y = adv_y + XW'(1);
                if (adv_diag) adv_x = adv_x - XW'(1);
            end
            default:
            begin
                adv_x = adv_x - XW'(1);
                if (adv_diag) adv_y = adv_y + XW'(1);
            end
        endcase
        adv_dec = walker_decision_reg[adv_idx] +
                  (adv_diag ? walker_step_diag_reg[adv_idx]
                            : $signed({1'b0, walker_step_even_reg[adv_idx]}));
    end

    // ---------------- span ends ----------------
    logic signed [XW-1:0] sx, lx, span_a, span_b;
    assign sx     = walker_x_reg[short_active_reg];
    assign lx     = walker_x_reg[long_edge_sel_reg];
    assign span_a = (sx > lx) ? lx : sx;
    assign span_b = (sx > lx) ? sx : lx;

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int e = 0; e < NUM_EDGES; e++)
            begin
                walker_x_reg[e]         <= '0;
                walker_y_reg[e]         <= '0;
                walker_y_begin_reg[e]   <= '0;
                walker_y_end_reg[e]     <= '0;
                walker_decision_reg[e]  <= '0;
                walker_step_even_reg[e] <= '0;
                walker_step_diag_reg[e] <= '0;
                walker_octant_reg[e]    <= OCT_X_RIGHT;
            end
            long_edge_sel_reg    <= EDGE_AB;
            short_first_sel_reg  <= EDGE_AB;
            short_second_sel_reg <= EDGE_AB;
            short_active_reg     <= EDGE_AB;
            old_y_reg            <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                for (int e = 0; e < NUM_EDGES; e++)
                begin
                    walker_x_reg[e]         <= su_x[e];
                    walker_y_reg[e]         <= $signed({1'b0, su_yb[e]});
                    walker_y_begin_reg[e]   <= su_yb[e];
                    walker_y_end_reg[e]     <= su_ye[e];
                    walker_decision_reg[e]  <= su_dec[e];
                    walker_step_even_reg[e] <= su_se[e];
                    walker_step_diag_reg[e] <= su_sd[e];
                    walker_octant_reg[e]    <= su_oct[e];
                end
            end
            if (cmd.select)
            begin
                long_edge_sel_reg <= sel_long;
                if (walker_y_begin_reg[sel_p] > walker_y_begin_reg[sel_q])
                begin
                    short_first_sel_reg  <= sel_q;
                    short_second_sel_reg <= sel_p;
                end
                else
                begin
                    short_first_sel_reg  <= sel_p;
                    short_second_sel_reg <= sel_q;
                end
            end
            if (cmd.adv_long || cmd.adv_short)
            begin
                walker_x_reg[adv_idx]        <= adv_x;
                walker_y_reg[adv_idx]        <= adv_y;
                walker_decision_reg[adv_idx] <= adv_dec;
            end
            if (cmd.capture_old)
                old_y_reg <= long_y;
            if (cmd.pick)
                short_active_reg <= pick_first ? short_first_sel_reg : short_second_sel_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= cmd.select || cmd.emit_span || cmd.emit_empty;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.select || cmd.emit_empty)
        begin
            span_valid_reg      <= 1'b0;
            span_done_reg       <= cmd.emit_empty || (sel_best == '0);
            span_row_reg        <= '0;
            span_x_start_reg    <= '0;
            span_x_end_reg      <= '0;
            span_zero_width_reg <= 1'b0;
        end
        else if (cmd.emit_span)
        begin
            span_valid_reg      <= 1'b1;
            span_done_reg       <= status.long_done;
            span_row_reg        <= FIELD_BITS'(long_y);
            span_x_start_reg    <= FIELD_BITS'(span_a);
            span_x_end_reg      <= FIELD_BITS'(span_b);
            span_zero_width_reg <= span_a == span_b;
        end
    end

    assign result_valid    = result_valid_reg;
    assign span_valid      = span_valid_reg;
    assign span_done       = span_done_reg;
    assign span_row        = span_row_reg;
    assign span_x_start    = span_x_start_reg;
    assign span_x_end      = span_x_end_reg;
    assign span_zero_width = span_zero_width_reg;

endmodule

@@ rtl/core/tsg_ctrl.sv @@
// ----------------------------------------------------------------------------
// tsg_ctrl
// Sequencer: load/select, then per request long-edge and short-edge stepping or an empty result.
// ----------------------------------------------------------------------------
module tsg_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                op,
    output logic                busy,
    output tsg_pkg::dp_cmd_t    cmd,
    input  tsg_pkg::dp_status_t status
);
    import tsg_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SELECT = 6'b000010,
        ST_CHECK  = 6'b000100,
        ST_LONG   = 6'b001000,
        ST_PICK   = 6'b010000,
        ST_SHORT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (op == OP_LOAD)
                    begin
                        cmd.load   = 1'b1;
                        state_next = ST_SELECT;
                    end
                    else
                        state_next = ST_CHECK;
                end
            end
            ST_SELECT:
            begin
                cmd.select = 1'b1;
                state_next = ST_IDLE;
            end
            ST_CHECK:
            begin
                if (status.long_done)
                begin
                    cmd.emit_empty = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    cmd.capture_old = 1'b1;
                    state_next      = ST_LONG;
                end
            end
            ST_LONG:
            begin
                if (status.long_moved)
                    state_next = ST_PICK;
                else
                    cmd.adv_long = 1'b1;
            end
            ST_PICK:
            begin
                cmd.pick   = 1'b1;
                state_next = ST_SHORT;
            end
            ST_SHORT:
            begin
                if (status.short_behind)
                    cmd.adv_short = 1'b1;
                else
                begin
                    cmd.emit_span = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = state_reg != ST_IDLE;

endmodule

@@ rtl/core/triangle_span_generator.sv @@
// ----------------------------------------------------------------------------
// triangle_span_generator
// Bresenham scanline walker: loads a triangle, returns one span per request.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  command   start & !busy        op, vertex_{a,b,c}_{x,y}
//  result    result_valid (1 cyc) span_valid, span_done, span_row,
//                                 span_x_start, span_x_end, span_zero_width
//
//  Load sets up the three walkers, then selects the long and short edges.
//  Next span: the long edge steps until its row changes, then the active short
//    edge steps up to that row; one Bresenham step per cycle in a single shared
//    step unit, so x-major edges take one step per pixel column. A request on a
//    finished triangle returns an empty result without stepping.
//  The result strobe is registered and appears in the same cycle as busy drops.
//  rst_n clears the walkers to an empty triangle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module triangle_span_generator #(
    parameter int COORD_BITS = tsg_pkg::COORD_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           op,
    input  logic [tsg_pkg::FIELD_BITS-1:0] vertex_a_x,
    input  logic [tsg_pkg::FIELD_BITS-1:0] vertex_a_y,
    input  logic [tsg_pkg::FIELD_BITS-1:0] vertex_b_x,
    input  logic [tsg_pkg::FIELD_BITS-1:0] vertex_b_y,
    input  logic [tsg_pkg::FIELD_BITS-1:0] vertex_c_x,
    input  logic [tsg_pkg::FIELD_BITS-1:0] vertex_c_y,
    output logic                           result_valid,
    output logic                           span_valid,
    output logic                           span_done,
    output logic [tsg_pkg::FIELD_BITS-1:0] span_row,
    output logic [tsg_pkg::FIELD_BITS-1:0] span_x_start,
    output logic [tsg_pkg::FIELD_BITS-1:0] span_x_end,
    output logic                           span_zero_width
);
    import tsg_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer: one transfer in flight at a time
    tsg_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .op     (op),
        .busy   (busy),
        .cmd    (cmd),
        .status (status)
    );

    // walkers, step unit and result registers
    tsg_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .vertex_a_x      (vertex_a_x),
        .vertex_a_y      (vertex_a_y),
        .vertex_b_x      (vertex_b_x),
        .vertex_b_y      (vertex_b_y),
        .vertex_c_x      (vertex_c_x),
        .vertex_c_y      (vertex_c_y),
        .result_valid    (result_valid),
        .span_valid      (span_valid),
        .span_done       (span_done),
        .span_row        (span_row),
        .span_x_start    (span_x_start),
        .span_x_end      (span_x_end),
        .span_zero_width (span_zero_width)
    );

    // accepted command always makes the block busy next cycle
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transfer did not start work");

    // every finished command delivers a result as busy drops
    a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> result_valid)
        else $error("command finished without a result");

    // result strobe only while the sequencer is idle
    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result strobe while still busy");

    // zero-width flag only on a real span
    a_zero_span: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && span_zero_width) |-> span_valid)
        else $error("zero width flagged without a span");

endmodule
